@@ sv/pmq_pkg.sv @@
// Package for the partitioned multi-queue: sizing constants, status and command codes,
// register indexes and the partition descriptor shared by the modules.
// No dependencies.
package pmq_pkg;

  localparam int StoreDepth = 32;
  localparam int NumQueues  = 4;
  localparam int DataWidth  = 32;

  // Register file always carries four partitions; NumQueues limits how many are usable.
  localparam int SlotCount = 4;
  localparam int AddrW     = (StoreDepth > 1) ? $clog2(StoreDepth) : 1;
  localparam int OffW      = 6;
  localparam int SizeW     = 6;
  localparam int ActW      = 3;
  localparam int QidW      = 2;
  localparam int CfgIdxW   = 3;
  localparam int CfgDataW  = 6;
  // Wide enough for the sum of four sizes and for the store depth itself.
  localparam int SumW      = ($clog2(StoreDepth + 1) > 8) ? $clog2(StoreDepth + 1) : 8;

  localparam logic [ActW-1:0]  ActiveReset = 3'd4;
  localparam logic [SizeW-1:0] SizeReset   = 6'd8;

  typedef enum logic [1:0] {
    StOk    = 2'd0,
    StFull  = 2'd1,
    StEmpty = 2'd2,
    StBadQ  = 2'd3
  } status_e;

  typedef enum logic {
    CmdEnq = 1'b0,
    CmdDeq = 1'b1
  } cmd_e;

  typedef enum logic [CfgIdxW-1:0] {
    RegActive = 3'd0,
    RegSize0  = 3'd1,
    RegSize1  = 3'd2,
    RegSize2  = 3'd3,
    RegSize3  = 3'd4
  } reg_e;

  typedef logic [SlotCount-1:0][SizeW-1:0] size_arr_t;
  typedef logic [SlotCount-1:0][OffW-1:0]  off_arr_t;

  typedef struct packed {
    logic [AddrW-1:0] base;
    logic [OffW-1:0]  len;
  } part_t;

endpackage

@@ sv/pmq_part.sv @@
// Partition lookup: base address and clipped length of the selected queue's partition.
// Depends on pmq_pkg.
module pmq_part (
  input  pmq_pkg::size_arr_t          sizes_i,
  input  logic [pmq_pkg::QidW-1:0]    queue_id_i,
  output pmq_pkg::part_t              part_o
);

  logic [pmq_pkg::SumW-1:0] base_sum;
  logic [pmq_pkg::SumW-1:0] size_ext;
  logic [pmq_pkg::SumW-1:0] room;
  logic [pmq_pkg::OffW-1:0] len;

  always_comb begin
    base_sum = '0;
    for (int i = 0; i < pmq_pkg::SlotCount; i++) begin
      if (i < int'(queue_id_i)) begin
        base_sum = base_sum + pmq_pkg::SumW'(sizes_i[i]);
      end
    end
  end

  always_comb begin
    size_ext = pmq_pkg::SumW'(sizes_i[queue_id_i]);
    room     = pmq_pkg::SumW'(pmq_pkg::StoreDepth) - base_sum;
    // Clip at the end of the store; a partition starting past it is empty.
    priority if (base_sum >= pmq_pkg::SumW'(pmq_pkg::StoreDepth)) begin
      len = '0;
    end else if (size_ext > room) begin
      len = room[pmq_pkg::OffW-1:0];
    end else begin
      len = sizes_i[queue_id_i];
    end
  end

  assign part_o.base = base_sum[pmq_pkg::AddrW-1:0];
  assign part_o.len  = len;

endmodule

@@ sv/pmq_store.sv @@
// Shared data store: one write port and one read port with registered read data.
// Depends on pmq_pkg.
module pmq_store (
  input  logic                            clk_i,
  input  logic                            wr_en_i,
  input  logic [pmq_pkg::AddrW-1:0]       wr_addr_i,
  input  logic [pmq_pkg::DataWidth-1:0]   wr_data_i,
  input  logic                            rd_en_i,
  input  logic [pmq_pkg::AddrW-1:0]       rd_addr_i,
  output logic [pmq_pkg::DataWidth-1:0]   rd_data_o
);

  logic [pmq_pkg::DataWidth-1:0] mem [pmq_pkg::StoreDepth];
  logic [pmq_pkg::DataWidth-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

@@ sv/partitioned_multi_queue.sv @@
// Partitioned multi-queue: up to four linear queues carved out of one shared store.
// Depends on pmq_pkg, pmq_part and pmq_store.
//
//   channel   handshake                  payload
//   request   start_i / busy_o           command_i, queue_id_i, write_data_i
//   result    done_o (one-cycle strobe)  read_data_o, status_o
//   config    cfg_valid_i / cfg_ready_o  cfg_index_i, cfg_data_i
//
// One request per cycle; busy_o stays low. The result appears in the cycle after the
// request is taken, set by the registered read port of the store.
// Reset: active count 4, all sizes 8, every head and tail at zero; the store holds
// no reset value and is only read at slots an earlier enqueue wrote.
// Writing any size register clears all heads and tails. Results cannot be stalled.
module partitioned_multi_queue (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   start_i,
  output logic                                   busy_o,
  input  logic                                   command_i,
  input  logic [pmq_pkg::QidW-1:0]               queue_id_i,
  input  logic signed [pmq_pkg::DataWidth-1:0]   write_data_i,
  output logic                                   done_o,
  output logic signed [pmq_pkg::DataWidth-1:0]   read_data_o,
  output logic [1:0]                             status_o,
  input  logic                                   cfg_valid_i,
  output logic                                   cfg_ready_o,
  input  logic [pmq_pkg::CfgIdxW-1:0]            cfg_index_i,
  input  logic [pmq_pkg::CfgDataW-1:0]           cfg_data_i
);

  logic [pmq_pkg::ActW-1:0]   active_q;
  pmq_pkg::size_arr_t         sizes_q;
  pmq_pkg::off_arr_t          head_q;
  pmq_pkg::off_arr_t          tail_q;

  logic                       done_q;
  pmq_pkg::status_e           status_q;
  pmq_pkg::status_e           status_d;
  logic                       deq_ok_q;

  logic                       accept;
  logic                       cfg_we;
  logic                       size_we;
  logic [pmq_pkg::ActW-1:0]   in_use;
  logic [pmq_pkg::OffW-1:0]   head_sel;
  logic [pmq_pkg::OffW-1:0]   tail_sel;
  logic                       enq_ok;
  logic                       deq_ok;
  logic [pmq_pkg::SumW-1:0]   addr_sum;
  logic [pmq_pkg::AddrW-1:0]  addr;
  logic [pmq_pkg::DataWidth-1:0] rd_data;
  pmq_pkg::part_t             part;

  assign busy_o      = 1'b0;
  assign cfg_ready_o = 1'b1;
  assign accept      = start_i && !busy_o;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;

  pmq_part u_part (
    .sizes_i    (sizes_q),
    .queue_id_i (queue_id_i),
    .part_o     (part)
  );

  // Request decode
  always_comb begin
    in_use   = (active_q > pmq_pkg::ActW'(pmq_pkg::NumQueues)) ?
               pmq_pkg::ActW'(pmq_pkg::NumQueues) : active_q;
    head_sel = head_q[queue_id_i];
    tail_sel = tail_q[queue_id_i];
    enq_ok   = 1'b0;
    deq_ok   = 1'b0;
    priority if (pmq_pkg::ActW'(queue_id_i) >= in_use) begin
      status_d = pmq_pkg::StBadQ;
    end else if (command_i == pmq_pkg::CmdEnq) begin
      if (tail_sel >= part.len) begin
        status_d = pmq_pkg::StFull;
      end else begin
        status_d = pmq_pkg::StOk;
        enq_ok   = 1'b1;
      end
    end else begin
      if (head_sel >= tail_sel) begin
        status_d = pmq_pkg::StEmpty;
      end else begin
        status_d = pmq_pkg::StOk;
        deq_ok   = 1'b1;
      end
    end
    addr_sum = pmq_pkg::SumW'(part.base) +
               pmq_pkg::SumW'((command_i == pmq_pkg::CmdEnq) ? tail_sel : head_sel);
    addr     = addr_sum[pmq_pkg::AddrW-1:0];
  end

  pmq_store u_store (
    .clk_i     (clk_i),
    .wr_en_i   (accept && enq_ok),
    .wr_addr_i (addr),
    .wr_data_i (write_data_i),
    .rd_en_i   (accept && deq_ok),
    .rd_addr_i (addr),
    .rd_data_o (rd_data)
  );

  // Configuration registers
  always_comb begin
    size_we = 1'b0;
    if (cfg_we) begin
      unique case (pmq_pkg::reg_e'(cfg_index_i))
        pmq_pkg::RegSize0, pmq_pkg::RegSize1,
        pmq_pkg::RegSize2, pmq_pkg::RegSize3: size_we = 1'b1;
        default:                              size_we = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= pmq_pkg::ActiveReset;
      for (int i = 0; i < pmq_pkg::SlotCount; i++) begin
        sizes_q[i] <= pmq_pkg::SizeReset;
      end
    end else if (cfg_we) begin
      unique case (pmq_pkg::reg_e'(cfg_index_i))
        pmq_pkg::RegActive: active_q   <= cfg_data_i[pmq_pkg::ActW-1:0];
        pmq_pkg::RegSize0:  sizes_q[0] <= cfg_data_i;
        pmq_pkg::RegSize1:  sizes_q[1] <= cfg_data_i;
        pmq_pkg::RegSize2:  sizes_q[2] <= cfg_data_i;
        pmq_pkg::RegSize3:  sizes_q[3] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Head and tail offsets; a size write clears all of them
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q <= '0;
      tail_q <= '0;
    end else if (size_we) begin
      head_q <= '0;
      tail_q <= '0;
    end else if (accept) begin
      if (enq_ok) begin
        tail_q[queue_id_i] <= tail_sel + pmq_pkg::OffW'(1);
      end
      if (deq_ok) begin
        head_q[queue_id_i] <= head_sel + pmq_pkg::OffW'(1);
      end
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q   <= 1'b0;
      status_q <= pmq_pkg::StOk;
      deq_ok_q <= 1'b0;
    end else begin
      done_q <= accept;
      if (accept) begin
        status_q <= status_d;
        deq_ok_q <= deq_ok;
      end
    end
  end

  assign done_o      = done_q;
  assign status_o    = status_q;
  assign read_data_o = deq_ok_q ? rd_data : '0;

`ifndef SYNTH
  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> done_o)
    else $error("request transaction produced no result");

  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !accept |=> !done_o)
    else $error("result strobe without a request transaction");

  a_head_le_tail: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (head_q[0] <= tail_q[0]) && (head_q[1] <= tail_q[1]) &&
    (head_q[2] <= tail_q[2]) && (head_q[3] <= tail_q[3]))
    else $error("head offset passed tail offset");

  a_size_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    size_we |=> (head_q == '0) && (tail_q == '0))
    else $error("size write did not clear the offsets");

  a_fail_zero_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (status_o != pmq_pkg::StOk)) |-> (read_data_o == '0))
    else $error("failed request returned nonzero data");
`endif

endmodule

@@ tb/partitioned_multi_queue_tb.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for partitioned_multi_queue: directed and random enqueue/dequeue
// traffic across changing partition layouts, checked against an in-bench queue predictor.
// Depends on pmq_pkg and the partitioned_multi_queue RTL.
module partitioned_multi_queue_tb;
  import pmq_pkg::*;

  localparam int StallLimit = 2000;
  localparam int RandPhases = 15;
  localparam int PhaseItems = 50;
  localparam logic [CfgIdxW-1:0] RegSpareLo = 3'd5;
  localparam logic [CfgIdxW-1:0] RegSpareHi = 3'd7;

  typedef struct {
    cmd_e                        cmd;
    logic [QidW-1:0]             qid;
    logic signed [DataWidth-1:0] wdata;
  } qreq_t;

  typedef struct {
    status_e                     st;
    logic signed [DataWidth-1:0] data;
  } qresp_t;

  logic                          clk_i = 1'b0;
  logic                          rst_ni = 1'b0;
  logic                          start_i = 1'b0;
  logic                          busy_o;
  logic                          command_i = 1'b0;
  logic [QidW-1:0]               queue_id_i = '0;
  logic signed [DataWidth-1:0]   write_data_i = '0;
  logic                          done_o;
  logic signed [DataWidth-1:0]   read_data_o;
  logic [1:0]                    status_o;
  logic                          cfg_valid_i = 1'b0;
  logic                          cfg_ready_o;
  logic [CfgIdxW-1:0]            cfg_index_i = '0;
  logic [CfgDataW-1:0]           cfg_data_i = '0;

  partitioned_multi_queue dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start_i),
    .busy_o       (busy_o),
    .command_i    (command_i),
    .queue_id_i   (queue_id_i),
    .write_data_i (write_data_i),
    .done_o       (done_o),
    .read_data_o  (read_data_o),
    .status_o     (status_o),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Shadow copy of the block's configuration and queue state.
  logic [ActW-1:0]             act_cnt = ActiveReset;
  logic [SizeW-1:0]            part_size [SlotCount] = '{default: SizeReset};
  logic [OffW-1:0]             head_ptr [SlotCount] = '{default: '0};
  logic [OffW-1:0]             tail_ptr [SlotCount] = '{default: '0};
  logic signed [DataWidth-1:0] shadow_mem [StoreDepth] = '{default: '0};

  qreq_t  pending_reqs[$];
  qresp_t expected_resps[$];
  int     err_cnt = 0;
  int     idle_cycles = 0;
  bit     steady = 1'b0;

  function automatic int queues_in_use();
    return (int'(act_cnt) > NumQueues) ? NumQueues : int'(act_cnt);
  endfunction

  function automatic qresp_t queue_access(qreq_t req);
    qresp_t r;
    int     base;
    int     span;
    int     i;
    r.data = '0;
    r.st   = StOk;
    if (int'(req.qid) >= queues_in_use()) begin
      r.st = StBadQ;
    end else begin
      base = 0;
      for (i = 0; i < int'(req.qid); i++) base += int'(part_size[i]);
      // Clip the partition at the end of the store.
      if (base >= StoreDepth) span = 0;
      else if (int'(part_size[req.qid]) > StoreDepth - base) span = StoreDepth - base;
      else span = int'(part_size[req.qid]);
      if (req.cmd == CmdEnq) begin
        if (int'(tail_ptr[req.qid]) >= span) begin
          r.st = StFull;
        end else begin
          shadow_mem[base + int'(tail_ptr[req.qid])] = req.wdata;
          tail_ptr[req.qid] = tail_ptr[req.qid] + 1'b1;
        end
      end else begin
        if (head_ptr[req.qid] >= tail_ptr[req.qid]) begin
          r.st = StEmpty;
        end else begin
          r.data = shadow_mem[base + int'(head_ptr[req.qid])];
          head_ptr[req.qid] = head_ptr[req.qid] + 1'b1;
        end
      end
    end
    return r;
  endfunction

  // Driver: predict on each accepted transaction, then present the next request.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (start_i && !busy_o) expected_resps.push_back(queue_access(pending_reqs.pop_front()));
      if (pending_reqs.size() != 0 && (steady || $urandom_range(0, 99) >= 10)) begin
        start_i      <= 1'b1;
        command_i    <= pending_reqs[0].cmd;
        queue_id_i   <= pending_reqs[0].qid;
        write_data_i <= pending_reqs[0].wdata;
      end else begin
        start_i <= 1'b0;
      end
    end
  end

  // Monitor: compare each result strobe against the oldest prediction; watch for stalls.
  always @(posedge clk_i) begin
    qresp_t exp_r;
    if (done_o) begin
      if (expected_resps.size() == 0) begin
        $error("unexpected result: read_data %0d status %0d", read_data_o, status_o);
        err_cnt++;
      end else begin
        exp_r = expected_resps.pop_front();
        if (status_o !== exp_r.st) begin
          $error("status mismatch: expected %0d actual %0d", exp_r.st, status_o);
          err_cnt++;
        end
        if (read_data_o !== exp_r.data) begin
          $error("read_data mismatch: expected %0d actual %0d", exp_r.data, read_data_o);
          err_cnt++;
        end
      end
    end
    if ((start_i && !busy_o) || done_o || (cfg_valid_i && cfg_ready_o)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= StallLimit) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  task automatic cfg_write(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] val);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    if (idx == RegActive) begin
      act_cnt = val[ActW-1:0];
    end else if (idx >= RegSize0 && idx <= RegSize3) begin
      part_size[idx - RegSize0] = val[SizeW-1:0];
      // Any size write clears every head and tail.
      for (int q = 0; q < SlotCount; q++) begin
        head_ptr[q] = '0;
        tail_ptr[q] = '0;
      end
    end
  endtask

  task automatic set_sizes(int s0, int s1, int s2, int s3);
    cfg_write(RegSize0, CfgDataW'(s0));
    cfg_write(RegSize1, CfgDataW'(s1));
    cfg_write(RegSize2, CfgDataW'(s2));
    cfg_write(RegSize3, CfgDataW'(s3));
  endtask

  task automatic push_req(cmd_e cmd, int qid, logic signed [DataWidth-1:0] wdata);
    qreq_t req;
    req.cmd   = cmd;
    req.qid   = QidW'(qid);
    req.wdata = wdata;
    pending_reqs.push_back(req);
  endtask

  // Hold until every request is taken and every result is back, then let the pipe settle.
  task automatic wait_drained();
    @(negedge clk_i);
    while (pending_reqs.size() != 0 || expected_resps.size() != 0 || start_i)
      @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  initial begin
    logic signed [DataWidth-1:0] corner [8];
    int in_use;
    int qid;
    corner = '{32'sh8000_0000, 32'sh7FFF_FFFF, 32'shFFFF_FFFF, 32'sh0000_0000,
               32'sh5555_5555, 32'shAAAA_AAAA, 32'sh0000_0001, 32'sh1234_5678};
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Reset layout: fill queue 0, overflow it, drain it, then underflow; then touch queues 1 and 3.
    for (int i = 0; i < 8; i++) push_req(CmdEnq, 0, corner[i]);
    push_req(CmdEnq, 0, 32'sh0BAD_0BAD);
    for (int i = 0; i < 9; i++) push_req(CmdDeq, 0, '0);
    push_req(CmdDeq, 1, 32'shFFFF_FFFF);
    push_req(CmdEnq, 3, 32'sh7FFF_FFFF);
    push_req(CmdDeq, 3, '0);
    wait_drained();

    // Zero active queues: every queue number is bad.
    cfg_write(RegActive, '0);
    push_req(CmdEnq, 0, 32'sh8000_0000);
    push_req(CmdDeq, 2, '0);
    wait_drained();

    // Over-range active count, spare indexes, partitions running off the store.
    cfg_write(RegActive, 6'h3F);
    cfg_write(RegSpareLo, 6'h15);
    cfg_write(RegSpareHi, 6'h2A);
    set_sizes(63, 0, 1, 32);
    push_req(CmdEnq, 1, 32'sh1111_1111);
    push_req(CmdEnq, 2, 32'sh2222_2222);
    push_req(CmdEnq, 3, 32'sh3333_3333);
    push_req(CmdDeq, 0, '0);
    wait_drained();

    for (int ph = 0; ph < RandPhases; ph++) begin
      steady = (ph >= 6 && ph <= 8);
      case (ph)
        0: begin
          cfg_write(RegActive, 6'd4);
          set_sizes(32, 0, 0, 0);
        end
        1: begin
          set_sizes(20, 20, 20, 20);
        end
        2: begin
          cfg_write(RegActive, 6'd1);
          set_sizes(1, 1, 1, 1);
        end
        3: begin
          cfg_write(RegActive, 6'd3);
          set_sizes(0, 0, 0, 0);
        end
        default: begin
          if ($urandom_range(0, 99) < 85)
            cfg_write(RegActive, {3'($urandom_range(0, 7)), 3'($urandom_range(1, 4))});
          else
            cfg_write(RegActive, 6'($urandom_range(0, 63)));
          if ($urandom_range(0, 99) < 70) begin
            for (int q = 0; q < SlotCount; q++)
              cfg_write(RegSize0 + CfgIdxW'(q), ($urandom_range(0, 99) < 80) ?
                        6'($urandom_range(0, 12)) : 6'($urandom_range(0, 63)));
          end
          if ($urandom_range(0, 99) < 10) cfg_write(RegSpareHi, 6'($urandom_range(0, 63)));
        end
      endcase
      in_use = queues_in_use();
      for (int i = 0; i < PhaseItems; i++) begin
        if (in_use > 0 && $urandom_range(0, 99) < 85) qid = $urandom_range(0, in_use - 1);
        else qid = $urandom_range(0, 3);
        push_req(($urandom_range(0, 99) < 55) ? CmdEnq : CmdDeq, qid,
                 ($urandom_range(0, 99) < 10) ? corner[$urandom_range(0, 1)] : $urandom);
      end
      wait_drained();
    end

    if (err_cnt == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

@@ sim.f @@
sv/pmq_pkg.sv
sv/pmq_part.sv
sv/pmq_store.sv
sv/partitioned_multi_queue.sv
tb/partitioned_multi_queue_tb.sv
